### rtl/fpwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered proquint word encoder: shared package
// Field widths, stage payload types, letter tables and the blocked-word
// screen used by the encoder pipeline.
// ----------------------------------------------------------------------------
package fpwe_pkg;

  localparam int VALUE_W   = 16;
  localparam int LETTER_W  = 7;
  localparam int BIT_IDX_W = 4;

  // Consonant codes that appear in the blocked substrings.
  localparam logic [3:0] CON_D = 4'd1;
  localparam logic [3:0] CON_F = 4'd2;
  localparam logic [3:0] CON_G = 4'd3;
  localparam logic [3:0] CON_H = 4'd4;
  localparam logic [3:0] CON_J = 4'd5;
  localparam logic [3:0] CON_K = 4'd6;
  localparam logic [3:0] CON_M = 4'd8;
  localparam logic [3:0] CON_N = 4'd9;
  localparam logic [3:0] CON_P = 4'd10;
  localparam logic [3:0] CON_S = 4'd12;
  localparam logic [3:0] CON_T = 4'd13;
  localparam logic [3:0] CON_Z = 4'd15;

  // Vowel codes that appear in the blocked substrings.
  localparam logic [1:0] VOW_A = 2'd0;
  localparam logic [1:0] VOW_I = 2'd1;
  localparam logic [1:0] VOW_U = 2'd3;

  // ASCII for b d f g h j k l m n p r s t v z.
  localparam logic [LETTER_W-1:0] CONS_TAB [16] = '{
    7'h62, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
    7'h6D, 7'h6E, 7'h70, 7'h72, 7'h73, 7'h74, 7'h76, 7'h7A
  };

  // ASCII for a i o u.
  localparam logic [LETTER_W-1:0] VOWEL_TAB [4] = '{7'h61, 7'h69, 7'h6F, 7'h75};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               orig_blocked;
    logic [VALUE_W-1:0] flip_blocked;
  } screen_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   coded;
    logic                 altered;
    logic [BIT_IDX_W-1:0] flipped_bit;
    logic                 stuck;
  } pick_t;

  // The word alternates consonant and vowel, so each blocked substring can
  // only sit at the positions where its letter classes line up.
  function automatic logic word_blocked(input logic [VALUE_W-1:0] v);
    logic [3:0] c0;
    logic [3:0] c1;
    logic [3:0] c2;
    logic [1:0] v0;
    logic [1:0] v1;
    logic       hit;
    c0  = v[15:12];
    v0  = v[11:10];
    c1  = v[9:6];
    v1  = v[5:4];
    c2  = v[3:0];
    hit = 1'b0;
    hit |= (c0 == CON_F) && (v0 == VOW_A) && (c1 == CON_G);
    hit |= (c1 == CON_F) && (v1 == VOW_A) && (c2 == CON_G);
    hit |= (c0 == CON_N) && (v0 == VOW_U) && (c1 == CON_D);
    hit |= (c1 == CON_N) && (v1 == VOW_U) && (c2 == CON_D);
    hit |= (c0 == CON_F) && (v0 == VOW_U) && (c1 == CON_K);
    hit |= (c1 == CON_F) && (v1 == VOW_U) && (c2 == CON_K);
    hit |= (c0 == CON_J) && (v0 == VOW_I) && (c1 == CON_H) && (v1 == VOW_A) && (c2 == CON_D);
    hit |= (c0 == CON_H) && (v0 == VOW_A) && (c1 == CON_M) && (v1 == VOW_A) && (c2 == CON_S);
    hit |= (v0 == VOW_I) && (c1 == CON_S) && (v1 == VOW_I) && (c2 == CON_S);
    hit |= (c0 == CON_N) && (v0 == VOW_A) && (c1 == CON_Z) && (v1 == VOW_I) && (c2 == CON_S);
    hit |= (c0 == CON_P) && (v0 == VOW_U) && (c1 == CON_T) && (v1 == VOW_I) && (c2 == CON_N);
    return hit;
  endfunction

endpackage

### rtl/fpwe_value_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value channel
// Valid/ready channel that carries one 16-bit value per beat.
// ----------------------------------------------------------------------------
interface fpwe_value_if
  import fpwe_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

### rtl/fpwe_word_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word channel
// Valid/ready channel that carries one encoded word and its status per beat.
// ----------------------------------------------------------------------------
interface fpwe_word_if
  import fpwe_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [LETTER_W-1:0]  letter_0;
  logic [LETTER_W-1:0]  letter_1;
  logic [LETTER_W-1:0]  letter_2;
  logic [LETTER_W-1:0]  letter_3;
  logic [LETTER_W-1:0]  letter_4;
  logic                 was_altered;
  logic [BIT_IDX_W-1:0] flipped_bit;
  logic                 still_blocked;
  logic [VALUE_W-1:0]   coded_value;

  modport source (
    output valid, output letter_0, output letter_1, output letter_2,
    output letter_3, output letter_4, output was_altered, output flipped_bit,
    output still_blocked, output coded_value, input ready
  );
  modport sink (
    input valid, input letter_0, input letter_1, input letter_2,
    input letter_3, input letter_4, input was_altered, input flipped_bit,
    input still_blocked, input coded_value, output ready
  );
endinterface

### rtl/fpwe_screen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen stage
// Checks the value and all sixteen single-bit flips against the blocked
// substrings in parallel and registers the results.
// ----------------------------------------------------------------------------
module fpwe_screen
  import fpwe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  fpwe_value_if.sink   item,
  output logic         valid,
  output screen_t      data,
  input  logic         down_ready
);

  screen_t data_next;

  always_comb begin
    data_next.value        = item.value_in;
    data_next.orig_blocked = word_blocked(item.value_in);
    for (int b = 0; b < VALUE_W; b++) begin
      data_next.flip_blocked[b] = word_blocked(item.value_in ^ (VALUE_W'(1) << b));
    end
  end

  assign item.ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      data <= data_next;
    end
  end

endmodule

### rtl/fpwe_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Select stage
// Picks the lowest flip whose word is clear when the original word is
// blocked, and forms the value that will be spelt.
// ----------------------------------------------------------------------------
module fpwe_select
  import fpwe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  input  screen_t up_data,
  output logic    up_ready,
  output logic    valid,
  output pick_t   data,
  input  logic    down_ready
);

  pick_t data_next;

  always_comb begin
    data_next.coded       = up_data.value;
    data_next.altered     = 1'b0;
    data_next.flipped_bit = '0;
    data_next.stuck       = up_data.orig_blocked;
    if (up_data.orig_blocked) begin
      for (int b = VALUE_W - 1; b >= 0; b--) begin
        if (!up_data.flip_blocked[b]) begin
          data_next.coded       = up_data.value ^ (VALUE_W'(1) << b);
          data_next.altered     = 1'b1;
          data_next.flipped_bit = BIT_IDX_W'(b);
          data_next.stuck       = 1'b0;
        end
      end
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

### rtl/fpwe_spell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spell stage
// Turns the chosen value into five ASCII letters and holds the result in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module fpwe_spell
  import fpwe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  input  pick_t        up_data,
  output logic         up_ready,
  fpwe_word_if.source  result
);

  assign up_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result.letter_0      <= CONS_TAB[up_data.coded[15:12]];
      result.letter_1      <= VOWEL_TAB[up_data.coded[11:10]];
      result.letter_2      <= CONS_TAB[up_data.coded[9:6]];
      result.letter_3      <= VOWEL_TAB[up_data.coded[5:4]];
      result.letter_4      <= CONS_TAB[up_data.coded[3:0]];
      result.was_altered   <= up_data.altered;
      result.flipped_bit   <= up_data.flipped_bit;
      result.still_blocked <= up_data.stuck;
      result.coded_value   <= up_data.coded;
    end
  end

endmodule

### rtl/filtered_proquint_word_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered proquint word encoder
// Encodes a 16-bit value as a five-letter word, steering round blocked
// substrings by flipping the lowest single bit that gives a clear word.
// ----------------------------------------------------------------------------
// The encoder takes one value per clock cycle while the word channel is not
// stalled, and passes it through the three register stages of the pipeline
// (screen, select, spell), the last of which is the output register.
// Back-pressure on the word channel holds the pipeline in place and drops
// nothing, and any empty stage still takes a new value.
module filtered_proquint_word_encoder_unit
  import fpwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fpwe_value_if.sink  item,
  fpwe_word_if.source result
);

  logic    scr_valid;
  screen_t scr_data;
  logic    scr_ready;
  logic    sel_valid;
  pick_t   sel_data;
  logic    sel_ready;

  fpwe_screen u_screen (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .valid      (scr_valid),
    .data       (scr_data),
    .down_ready (scr_ready)
  );

  fpwe_select u_select (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (scr_valid),
    .up_data    (scr_data),
    .up_ready   (scr_ready),
    .valid      (sel_valid),
    .data       (sel_data),
    .down_ready (sel_ready)
  );

  fpwe_spell u_spell (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sel_valid),
    .up_data  (sel_data),
    .up_ready (sel_ready),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    result.ready |-> item.ready)
    else $error("Input stalled while the output is being drained.");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.was_altered && result.still_blocked))
    else $error("Word reported both altered and still blocked.");

  a_bit_zero : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.was_altered) |-> (result.flipped_bit == '0))
    else $error("Flipped bit index set on an unaltered word.");

  a_clear_word : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.still_blocked) |-> !word_blocked(result.coded_value))
    else $error("Emitted word contains a blocked substring.");

  a_letters_match : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.letter_0 == CONS_TAB[result.coded_value[15:12]]) &&
                     (result.letter_4 == CONS_TAB[result.coded_value[3:0]]))
    else $error("Letters do not spell the coded value.");
`endif

endmodule
